// File: rtl/lrts_pkg.sv
// Shared operation codes, status codes and sequencer states for the least-run thread scheduler.
`timescale 1ns / 1ps

package lrts_pkg;

  localparam int unsigned OP_WIDTH     = 2;
  localparam int unsigned STATUS_WIDTH = 2;
  localparam int unsigned TID_WIDTH    = 6;
  localparam int unsigned AGE_WIDTH    = 16;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_CREATE = 2'd0,
    OP_SCHED  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_JOIN   = 2'd3
  } op_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_ALL_DONE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_JOIN_CHK,
    S_DISP,
    S_INS_INIT,
    S_INS_STEP,
    S_INS_CMP,
    S_POP,
    S_POP_WAIT,
    S_RESULT
  } state_t;

endpackage

// File: rtl/least_run_thread_scheduler.sv
// Least-run thread scheduler: sorted ready queue in memory walked by one shared age comparator.
`timescale 1ns / 1ps

// The block takes one operation at a time on the input channel (operation, thread_id)
// and returns one result on the output channel (status_code, new_thread_id,
// running_thread_id, running_age). Both channels use valid and ready; a transfer
// happens when both are high at a rising clock edge.
// The ready queue lives in a single-port-read, single-port-write memory kept as a
// ring buffer, so removing the head costs one read. Insertion walks backward from
// the tail through the one age comparator, reading an entry in S_INS_STEP and
// comparing it in S_INS_CMP, where a greater age moves the entry up by one place.
// The input is ready only while the sequencer is idle.
// After reset the completed-thread memory is cleared one entry a cycle, and the
// input stays not ready until the last entry is cleared. Thread 0 then runs at age zero.
// The result sits in an output register, so a stalled receiver does not block the
// next input transfer; a further result waits until the register is free.
module least_run_thread_scheduler #(
  parameter int MAX_THREADS = 64,
  parameter int AGE_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lrts_pkg::OP_WIDTH-1:0]     operation,
  input  logic [lrts_pkg::TID_WIDTH-1:0]    thread_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lrts_pkg::STATUS_WIDTH-1:0] status_code,
  output logic [lrts_pkg::TID_WIDTH-1:0]    new_thread_id,
  output logic [lrts_pkg::TID_WIDTH-1:0]    running_thread_id,
  output logic [lrts_pkg::AGE_WIDTH-1:0]    running_age
);

  import lrts_pkg::*;

  localparam int IDW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW  = $clog2(MAX_THREADS + 1);
  localparam int EW  = IDW + AGE_BITS;
  localparam logic [IDW-1:0] LAST    = IDW'(MAX_THREADS - 1);
  localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_THREADS);

  logic [EW-1:0] queue_mem [MAX_THREADS];
  logic          mark_mem  [MAX_THREADS];

  state_t state, state_next;

  logic [IDW-1:0]      head, tail, clr_addr, run_id, ins_id, ins_pos;
  logic [CW-1:0]       count, next_id, ins_left;
  logic [AGE_BITS-1:0] run_age, ins_age;
  logic                run_done, pop_after;
  op_t                 op_q;
  logic [TID_WIDTH-1:0] tid_q;
  status_t             status_q;
  logic [TID_WIDTH-1:0] new_id_q;

  logic [EW-1:0]  q_rd;
  logic           mark_rd;
  logic           q_we, mark_we, mark_wdata;
  logic [IDW-1:0] q_waddr, q_raddr, mark_waddr, mark_raddr;
  logic [EW-1:0]  q_wdata;

  logic [AGE_BITS-1:0] age_inc, rd_age;
  logic [IDW-1:0]      rd_id, ins_prev, tail_inc, head_inc, tid_idx;
  logic                tid_ok, rd_greater;

  status_t                 out_status;
  logic [TID_WIDTH-1:0]    out_new_id, out_run_id;
  logic [AGE_WIDTH-1:0]    out_run_age;

  assign age_inc    = (&run_age) ? run_age : run_age + 1'b1;
  assign rd_age     = q_rd[AGE_BITS-1:0];
  assign rd_id      = q_rd[EW-1:AGE_BITS];
  assign rd_greater = rd_age > ins_age;
  assign ins_prev   = (ins_pos == '0) ? LAST : ins_pos - 1'b1;
  assign tail_inc   = (tail == LAST) ? '0 : tail + 1'b1;
  assign head_inc   = (head == LAST) ? '0 : head + 1'b1;
  assign tid_ok     = 32'(tid_q) < MAX_THREADS;
  assign tid_idx    = IDW'(tid_q);

  assign status_code       = out_status;
  assign new_thread_id     = out_new_id;
  assign running_thread_id = out_run_id;
  assign running_age       = out_run_age;

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rd <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    q_we       = 1'b0;
    q_waddr    = ins_pos;
    q_wdata    = {ins_id, ins_age};
    q_raddr    = head;
    mark_we    = 1'b0;
    mark_waddr = tid_idx;
    mark_wdata = 1'b0;
    mark_raddr = tid_idx;
    case (state)
      S_CLEAR: begin
        mark_we    = 1'b1;
        mark_waddr = clr_addr;
        if (clr_addr == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_CREATE: state_next = (next_id >= CNT_MAX) ? S_RESULT : S_INS_INIT;
          OP_SCHED:  state_next = (count == '0) ? S_RESULT : S_DISP;
          OP_EXIT:   state_next = (count == '0) ? S_RESULT : S_DISP;
          OP_JOIN: begin
            if (tid_ok) begin
              state_next = S_JOIN_CHK;
            end else begin
              state_next = (count == '0) ? S_RESULT : S_DISP;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_JOIN_CHK: begin
        if (mark_rd) begin
          mark_we    = 1'b1;
          state_next = S_RESULT;
        end else begin
          state_next = (count == '0) ? S_RESULT : S_DISP;
        end
      end
      S_DISP: begin
        if (run_done) begin
          mark_we    = 1'b1;
          mark_waddr = run_id;
          mark_wdata = 1'b1;
          state_next = S_POP;
        end else begin
          state_next = S_INS_INIT;
        end
      end
      S_INS_INIT: begin
        if (count >= CNT_MAX) begin
          state_next = pop_after ? S_POP : S_RESULT;
        end else begin
          state_next = S_INS_STEP;
        end
      end
      S_INS_STEP: begin
        if (ins_left == '0) begin
          q_we       = 1'b1;
          state_next = pop_after ? S_POP : S_RESULT;
        end else begin
          q_raddr    = ins_prev;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        q_we = 1'b1;
        if (rd_greater) begin
          q_wdata    = q_rd;
          state_next = S_INS_STEP;
        end else begin
          state_next = pop_after ? S_POP : S_RESULT;
        end
      end
      S_POP: begin
        state_next = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      next_id   <= CW'(1);
      run_id    <= '0;
      run_age   <= '0;
      run_done  <= 1'b0;
      pop_after <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr != LAST) begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q      <= op_t'(operation);
            tid_q     <= thread_id;
            status_q  <= ST_OK;
            new_id_q  <= '0;
            pop_after <= 1'b0;
          end
        end
        S_DECODE: begin
          case (op_q)
            OP_CREATE: begin
              if (next_id >= CNT_MAX) begin
                status_q <= ST_EXHAUSTED;
              end else begin
                new_id_q <= TID_WIDTH'(next_id);
                ins_id   <= IDW'(next_id);
                ins_age  <= '0;
                next_id  <= next_id + 1'b1;
              end
            end
            OP_EXIT: begin
              run_done <= 1'b1;
              if (count == '0) begin
                status_q <= ST_ALL_DONE;
              end
            end
            OP_JOIN: begin
              if (!tid_ok) begin
                status_q <= ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
        S_JOIN_CHK: begin
          if (!mark_rd) begin
            status_q <= ST_NOT_FOUND;
          end
        end
        S_DISP: begin
          run_age   <= age_inc;
          pop_after <= 1'b1;
          ins_id    <= run_id;
          ins_age   <= age_inc;
        end
        S_INS_INIT: begin
          ins_pos  <= tail;
          ins_left <= count;
        end
        S_INS_STEP: begin
          if (ins_left == '0) begin
            count <= count + 1'b1;
            tail  <= tail_inc;
          end
        end
        S_INS_CMP: begin
          if (rd_greater) begin
            ins_pos  <= ins_prev;
            ins_left <= ins_left - 1'b1;
          end else begin
            count <= count + 1'b1;
            tail  <= tail_inc;
          end
        end
        S_POP_WAIT: begin
          run_id   <= rd_id;
          run_age  <= rd_age;
          run_done <= 1'b0;
          head     <= head_inc;
          count    <= count - 1'b1;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_status  <= status_q;
            out_new_id  <= new_id_q;
            out_run_id  <= TID_WIDTH'(run_id);
            out_run_age <= AGE_WIDTH'(run_age);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
